@@ design/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Types and constants shared by the integer-to-ASCII formatter modules.
// ----------------------------------------------------------------------------
package itoa_pkg;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEX  = 2'd2,
    OP_OCT  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
    logic [5:0]  precision;
    logic        has_precision;
    logic        force_sign;
    logic        space_sign;
    logic        upper_case;
    logic        alternate;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } out_beat_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] mag;
    logic [5:0]  prec;
    logic [7:0]  sign_ch;
    logic        has_sign;
    logic        hex_pfx;
    logic        oct_alt;
    logic        upper;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIGITS,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_EMIT
  } bk_state_t;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam int         DIG_MAX  = 64;
  localparam int         DIG_W    = 7;

endpackage

@@ design/itoa_front.sv @@
// ----------------------------------------------------------------------------
// itoa_front
// Accepts input beats, resolves sign, magnitude, precision and prefixes.
// ----------------------------------------------------------------------------
module itoa_front #(
  parameter int MAX_PREC = 60
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  itoa_pkg::in_beat_t in_data,
  output logic              job_valid,
  input  logic              job_stall,
  output itoa_pkg::job_t    job_data
);
  import itoa_pkg::*;

  logic  full_r, full_nxt;
  job_t  job_r, job_nxt;
  logic  neg;
  logic [5:0] prec;

  assign in_stall  = full_r && job_stall;
  assign job_valid = full_r;
  assign job_data  = job_r;

  always_comb begin
    neg  = (in_data.op == OP_SDEC) && in_data.value[63];
    prec = in_data.has_precision ? in_data.precision : 6'd1;
    if (prec > 6'(MAX_PREC)) prec = 6'(MAX_PREC);
    job_nxt.op       = in_data.op;
    job_nxt.mag      = neg ? (64'd0 - in_data.value) : in_data.value;
    job_nxt.prec     = prec;
    job_nxt.has_sign = (in_data.op == OP_SDEC) &&
                       (neg || in_data.force_sign || in_data.space_sign);
    job_nxt.sign_ch  = neg ? CH_MINUS : (in_data.force_sign ? CH_PLUS : CH_SPACE);
    job_nxt.hex_pfx  = (in_data.op == OP_HEX) && in_data.alternate &&
                       (in_data.value != 64'd0);
    job_nxt.oct_alt  = (in_data.op == OP_OCT) && in_data.alternate;
    job_nxt.upper    = in_data.upper_case;
  end

  always_comb begin
    full_nxt = full_r;
    if (!in_stall && in_valid) full_nxt = 1'b1;
    else if (full_r && !job_stall) full_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) full_r <= 1'b0;
    else full_r <= full_nxt;
    if (in_valid && !in_stall) job_r <= job_nxt;
  end

endmodule

@@ design/itoa_back.sv @@
// ----------------------------------------------------------------------------
// itoa_back
// Extracts digits into a buffer, then emits the text one character per beat.
// ----------------------------------------------------------------------------
module itoa_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_stall,
  input  itoa_pkg::job_t     job_data,
  output logic               out_valid,
  input  logic               out_stall,
  output itoa_pkg::out_beat_t out_data
);
  import itoa_pkg::*;

  bk_state_t  st_r, st_nxt;
  job_t       job_r;
  logic [63:0] mag_r, mag_nxt;
  logic [7:0]  dig_r [DIG_MAX];
  logic [DIG_W-1:0] nd_r, nd_nxt;
  logic        ov_r, ov_nxt;
  out_beat_t   ob_r, ob_nxt;
  logic        take, room, wr_dig;
  logic [7:0]  wr_ch;
  logic [3:0]  d;
  logic [2:0]  ph_r, ph_nxt;
  logic [63:0] t_r, t_nxt;
  logic [63:0] q;
  logic [4:0]  rem5;
  logic        fix, dig_go;
  logic [7:0]  wr_val, rd_r;
  logic [DIG_W-1:0] rd_addr;

  assign job_stall = (st_r != ST_IDLE);
  assign take      = job_valid && (st_r == ST_IDLE);
  assign room      = !ov_r || !out_stall;
  assign out_valid = ov_r;
  assign out_data  = ob_r;

  // divide by ten: 0.8*mag built as a shift-add series,
  // quotient is that over 8, short by at most one; fixed on the low remainder bits
  always_comb begin
    case (ph_r)
      3'd0:    t_nxt = (mag_r >> 1) + (mag_r >> 2);
      3'd1:    t_nxt = t_r + (t_r >> 4);
      3'd2:    t_nxt = t_r + (t_r >> 8);
      3'd3:    t_nxt = t_r + (t_r >> 16);
      3'd4:    t_nxt = t_r + (t_r >> 32);
      default: t_nxt = t_r;
    endcase
    q    = t_r >> 3;
    rem5 = mag_r[4:0] - ({q[1:0], 3'b000} + {q[3:0], 1'b0});
    fix  = (rem5 > 5'd9);
    case (job_r.op)
      OP_HEX:  d = mag_r[3:0];
      OP_OCT:  d = {1'b0, mag_r[2:0]};
      default: d = fix ? 4'(rem5 - 5'd10) : rem5[3:0];
    endcase
  end

  always_comb begin
    ph_nxt = 3'd0;
    if (st_r == ST_DIGITS && mag_r != 64'd0 && (job_r.op inside {OP_SDEC, OP_UDEC}))
      ph_nxt = (ph_r == 3'd5) ? 3'd0 : ph_r + 3'd1;
  end

  always_comb begin
    mag_nxt = mag_r;
    case (job_r.op)
      OP_HEX:  mag_nxt = mag_r >> 4;
      OP_OCT:  mag_nxt = mag_r >> 3;
      default: mag_nxt = q + 64'(fix);
    endcase
    wr_ch = (d < 4'd10) ? (CH_ZERO + 8'(d))
          : ((job_r.upper ? CH_UA : CH_LA) + 8'(d) - 8'd10);
    wr_val = (mag_r != 64'd0) ? wr_ch : CH_ZERO;
    dig_go = (mag_r != 64'd0) &&
             ((job_r.op inside {OP_HEX, OP_OCT}) || ph_r == 3'd5);
  end

  logic more_sign, more_pfx;
  logic [7:0] top_ch;
  always_comb begin
    top_ch = rd_r;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (take) st_nxt = ST_DIGITS;
      ST_DIGITS: begin
        if (mag_r == 64'd0 && 7'(job_r.prec) <= nd_r &&
            !(job_r.oct_alt && (nd_r == 7'd0 || top_ch != CH_ZERO))) begin
          if (job_r.has_sign) st_nxt = ST_SIGN;
          else if (job_r.hex_pfx) st_nxt = ST_PFX0;
          else if (nd_r != 7'd0) st_nxt = ST_EMIT;
          else st_nxt = ST_IDLE;
        end
      end
      ST_SIGN:   if (room) st_nxt = job_r.hex_pfx ? ST_PFX0 :
                                   (nd_r != 7'd0 ? ST_EMIT : ST_IDLE);
      ST_PFX0:   if (room) st_nxt = ST_PFXX;
      ST_PFXX:   if (room) st_nxt = (nd_r != 7'd0) ? ST_EMIT : ST_IDLE;
      ST_EMIT:   if (room && nd_r == 7'd1) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r && out_stall;
    ob_nxt = ob_r;
    nd_nxt = nd_r;
    wr_dig = 1'b0;
    more_sign = job_r.hex_pfx || (nd_r != 7'd0);
    more_pfx  = (nd_r != 7'd0);
    case (st_r)
      ST_IDLE: if (take) nd_nxt = '0;
      ST_DIGITS: begin
        if (mag_r != 64'd0) begin
          if (dig_go) begin
            wr_dig = 1'b1;
            nd_nxt = nd_r + 7'd1;
          end
        end else if (7'(job_r.prec) > nd_r) begin
          wr_dig = 1'b1;
          nd_nxt = nd_r + 7'd1;
        end else if (job_r.oct_alt && (nd_r == 7'd0 || top_ch != CH_ZERO)) begin
          wr_dig = 1'b1;
          nd_nxt = nd_r + 7'd1;
        end
      end
      ST_SIGN: if (room) begin
        ov_nxt = 1'b1;
        ob_nxt = '{character: job_r.sign_ch, last: !more_sign};
      end
      ST_PFX0: if (room) begin
        ov_nxt = 1'b1;
        ob_nxt = '{character: CH_ZERO, last: 1'b0};
      end
      ST_PFXX: if (room) begin
        ov_nxt = 1'b1;
        ob_nxt = '{character: (job_r.upper ? CH_UX : CH_LX), last: !more_pfx};
      end
      ST_EMIT: if (room) begin
        ov_nxt = 1'b1;
        ob_nxt = '{character: top_ch, last: (nd_r == 7'd1)};
        nd_nxt = nd_r - 7'd1;
      end
      default: ;
    endcase
    rd_addr = nd_nxt - 7'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
    end
    nd_r <= nd_nxt;
    ob_r <= ob_nxt;
    ph_r <= ph_nxt;
    t_r  <= t_nxt;
    if (take) begin
      job_r <= job_data;
      mag_r <= job_data.mag;
    end else if (st_r == ST_DIGITS && dig_go) begin
      mag_r <= mag_nxt;
    end
    if (wr_dig) dig_r[nd_r[5:0]] <= wr_val;
    // holds the top digit, dig_r[nd_r-1]
    rd_r <= wr_dig ? wr_val : dig_r[rd_addr[5:0]];
  end

endmodule

@@ design/integer_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style integer conversion, one ASCII character per output beat.
// ----------------------------------------------------------------------------
// The back end takes an item, then builds its digits: a decimal digit comes
// out of a shift-add divide by ten while the value is still nonzero, while
// each hex or octal digit and each padding zero is written directly, and a
// final step closes the digit pass. It then emits one character per cycle
// while out_stall is low. The back end handles one item at a time while the
// front register holds the next one.
module integer_to_ascii_formatter #(
  parameter int MAX_PREC = 60
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  itoa_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output itoa_pkg::out_beat_t out_data
);
  import itoa_pkg::*;

  logic job_valid, job_stall;
  job_t job_data;

  itoa_front #(.MAX_PREC(MAX_PREC)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid, .job_stall, .job_data
  );

  itoa_back u_back (
    .clk, .rst_n, .job_valid, .job_stall, .job_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

@@ tb/integer_to_ascii_formatter_tb.sv @@
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Drives conversion requests through the valid/stall input channel, predicts
// the printf-style text of each one and checks every output character beat
// in order. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;
  import itoa_pkg::*;

  localparam int MAX_PREC = 60;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IN_W = $bits(in_beat_t);

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  out_beat_t out_data;

  out_beat_t expected_chars[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        idle_enable = 1'b1;

  integer_to_ascii_formatter #(.MAX_PREC(MAX_PREC)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  function automatic void format_integer(input in_beat_t b);
    logic [7:0]  digits[$];
    logic [7:0]  text[$];
    logic [63:0] mag;
    logic [3:0]  d;
    int          prec;
    bit          neg;
    out_beat_t   ch;
    mag = b.value;
    neg = 1'b0;
    prec = b.has_precision ? int'(b.precision) : 1;
    if (prec > MAX_PREC) prec = MAX_PREC;
    if (op_t'(b.op) == OP_SDEC && b.value[63]) begin
      neg = 1'b1;
      mag = -b.value;
    end
    while (mag != 0) begin
      case (op_t'(b.op))
        OP_HEX: begin d = mag[3:0]; mag = mag >> 4; end
        OP_OCT: begin d = {1'b0, mag[2:0]}; mag = mag >> 3; end
        default: begin d = 4'(mag % 10); mag = mag / 10; end
      endcase
      if (d < 10) digits.push_front(CH_ZERO + 8'(d));
      else digits.push_front(8'(d - 10) + (b.upper_case ? CH_UA : CH_LA));
    end
    while (digits.size() < prec) digits.push_front(CH_ZERO);
    if (op_t'(b.op) == OP_OCT && b.alternate &&
        (digits.size() == 0 || digits[0] != CH_ZERO))
      digits.push_front(CH_ZERO);
    if (op_t'(b.op) == OP_SDEC) begin
      if (neg) text.push_back(CH_MINUS);
      else if (b.force_sign) text.push_back(CH_PLUS);
      else if (b.space_sign) text.push_back(CH_SPACE);
    end
    if (op_t'(b.op) == OP_HEX && b.alternate && b.value != 0) begin
      text.push_back(CH_ZERO);
      text.push_back(b.upper_case ? CH_UX : CH_LX);
    end
    foreach (digits[i]) text.push_back(digits[i]);
    foreach (text[i]) begin
      ch.character = text[i];
      ch.last = (i == text.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[integer_to_ascii_formatter] ERROR");
      $finish;
    end
    if (rst_n)
      out_stall <= idle_enable ? ($urandom_range(99) < 38) : 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected beat char=%h last=%b",
                                      out_data.character, out_data.last);
      end else begin
        if (out_data !== expected_chars[0]) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: expected char=%h last=%b, got char=%h last=%b",
                     expected_chars[0].character, expected_chars[0].last,
                     out_data.character, out_data.last);
        end
        void'(expected_chars.pop_front());
      end
    end
  end

  task automatic send_beat(input in_beat_t b);
    while (idle_enable && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    format_integer(b);
  endtask

  function automatic in_beat_t beat_of(input op_t op, input logic [63:0] v,
                                       input int prec, input bit hp,
                                       input bit fs, input bit ss,
                                       input bit uc, input bit alt);
    in_beat_t b;
    b.op = op; b.value = v; b.precision = 6'(prec); b.has_precision = hp;
    b.force_sign = fs; b.space_sign = ss; b.upper_case = uc; b.alternate = alt;
    return b;
  endfunction

  function automatic logic [63:0] random_value();
    case ($urandom_range(5))
      0: return 64'(0);
      1: return {$urandom, $urandom};
      2: return 64'($urandom_range(1000));
      3: return -64'($urandom_range(1000));
      4: return {$urandom, $urandom} >> $urandom_range(63);
      default: return {1'b1, 63'(0)} ^ 64'($urandom_range(3));
    endcase
  endfunction

  task automatic test_extremes();
    send_beat(beat_of(OP_SDEC, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0, 0));
    send_beat(beat_of(OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 1, 0, 0, 0));
    send_beat(beat_of(OP_SDEC, '1, 5, 1, 0, 1, 0, 0));
    send_beat(beat_of(OP_UDEC, '1, 0, 0, 1, 1, 1, 1));
    send_beat(beat_of(OP_HEX, '1, 0, 0, 0, 0, 1, 1));
    send_beat(beat_of(OP_HEX, 64'hABCD_EF01_2345_6789, 0, 0, 0, 0, 0, 1));
    send_beat(beat_of(OP_OCT, '1, 0, 0, 0, 0, 0, 1));
    send_beat(beat_of(OP_OCT, 64'o17, 1, 1, 0, 0, 0, 1));
    send_beat(beat_of(OP_OCT, 64'o17, 5, 1, 0, 0, 0, 1));
    send_beat(beat_of(OP_UDEC, 64'd42, 60, 1, 0, 0, 0, 0));
    send_beat(beat_of(OP_UDEC, 64'd42, 63, 1, 0, 0, 0, 0));
    send_beat(beat_of(OP_HEX, 64'h1F, 63, 1, 0, 0, 1, 1));
  endtask

  task automatic test_zero_cases();
    send_beat(beat_of(OP_SDEC, 0, 0, 1, 0, 0, 0, 0));
    send_beat(beat_of(OP_SDEC, 0, 0, 1, 1, 0, 0, 0));
    send_beat(beat_of(OP_SDEC, 0, 0, 1, 0, 1, 0, 0));
    send_beat(beat_of(OP_UDEC, 0, 0, 1, 0, 0, 0, 0));
    send_beat(beat_of(OP_HEX, 0, 0, 1, 0, 0, 1, 1));
    send_beat(beat_of(OP_HEX, 0, 0, 0, 0, 0, 0, 1));
    send_beat(beat_of(OP_OCT, 0, 0, 1, 0, 0, 0, 1));
    send_beat(beat_of(OP_OCT, 0, 0, 1, 0, 0, 0, 0));
    send_beat(beat_of(OP_OCT, 0, 3, 1, 0, 0, 0, 1));
  endtask

  task automatic test_random(input int count);
    in_beat_t b;
    for (int i = 0; i < count; i++) begin
      idle_enable = !(i >= count / 2 && i < count / 2 + 60);
      b = in_beat_t'(IN_W'({$urandom, $urandom, $urandom}));
      b.value = random_value();
      if ($urandom_range(3) != 0) b.precision = 6'($urandom_range(12));
      send_beat(b);
    end
    idle_enable = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_zero_cases();
    test_random(450);
    in_valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0)
      $display("[integer_to_ascii_formatter] OK");
    else
      $display("[integer_to_ascii_formatter] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
design/itoa_pkg.sv
design/itoa_front.sv
design/itoa_back.sv
design/integer_to_ascii_formatter.sv
tb/integer_to_ascii_formatter_tb.sv
